// File: rtl/core/qnorm_pkg.sv
// ----------------------------------------------------------------------------
// qnorm_pkg
// Widths, register codes and shared types for the quaternion normaliser.
// ----------------------------------------------------------------------------
package qnorm_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;
    localparam int LANES     = 4;

    localparam int CFG_W     = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam int OFRAC = OUT_WIDTH - 2;
    localparam int SHIFT = 2 * OFRAC + 2;
    localparam int MAG_W = IN_WIDTH;
    localparam int SQ_W  = 2 * IN_WIDTH - 1;
    localparam int SUM_W = SQ_W + 2;
    localparam int D_W   = SQ_W + SHIFT;
    localparam int R_W   = OFRAC + 2;
    localparam int P_W   = R_W + SUM_W;
    localparam int T_W   = P_W + R_W + 1;

    localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH_SQUARED = '0;
    localparam logic [CFG_W-1:0]     MIN_LENGTH_SQUARED_RESET = CFG_W'(1);

    typedef logic [SQ_W-1:0] sq_t;
    typedef logic [R_W-1:0]  root_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LANES-1:0] neg;
        logic             too_short;
    } ctl_t;

endpackage

// File: rtl/core/qnorm_in_if.sv
// ----------------------------------------------------------------------------
// qnorm_in_if
// Input channel: one quaternion per beat, four signed components.
// ----------------------------------------------------------------------------
interface qnorm_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [qnorm_pkg::IN_WIDTH-1:0] in_w;
    logic signed [qnorm_pkg::IN_WIDTH-1:0] in_x;
    logic signed [qnorm_pkg::IN_WIDTH-1:0] in_y;
    logic signed [qnorm_pkg::IN_WIDTH-1:0] in_z;

    modport source (output valid, output in_w, output in_x, output in_y, output in_z,
                    input ready);
    modport sink   (input valid, input in_w, input in_x, input in_y, input in_z,
                    output ready);

endinterface

// File: rtl/core/qnorm_out_if.sv
// ----------------------------------------------------------------------------
// qnorm_out_if
// Output channel: one normalised quaternion and its error flag per beat.
// ----------------------------------------------------------------------------
interface qnorm_out_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [qnorm_pkg::OUT_WIDTH-1:0] out_w;
    logic signed [qnorm_pkg::OUT_WIDTH-1:0] out_x;
    logic signed [qnorm_pkg::OUT_WIDTH-1:0] out_y;
    logic signed [qnorm_pkg::OUT_WIDTH-1:0] out_z;
    logic                                  too_short;

    modport source (output valid, output out_w, output out_x, output out_y, output out_z,
                    output too_short, input ready);
    modport sink   (input valid, input out_w, input out_x, input out_y, input out_z,
                    input too_short, output ready);

endinterface

// File: rtl/core/qnorm_cfg.sv
// ----------------------------------------------------------------------------
// qnorm_cfg
// APB register bank holding the minimum squared length.
// ----------------------------------------------------------------------------
module qnorm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qnorm_pkg::APB_AW-1:0]   paddr,
    input  logic [qnorm_pkg::APB_DW-1:0]   pwdata,
    output logic [qnorm_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output logic [qnorm_pkg::CFG_W-1:0]    min_length_squared
);

    logic [qnorm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                            wr_en;
    logic [qnorm_pkg::CFG_W-1:0]     min_len_reg;
    logic [qnorm_pkg::CFG_W-1:0]     min_len_next;

    assign reg_idx = paddr[qnorm_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign min_length_squared = min_len_reg;

    always_comb
    begin
        min_len_next = min_len_reg;
        if (wr_en && (reg_idx == qnorm_pkg::REG_MIN_LENGTH_SQUARED))
        begin
            min_len_next = pwdata[qnorm_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            qnorm_pkg::REG_MIN_LENGTH_SQUARED: prdata = qnorm_pkg::APB_DW'(min_len_reg);
            default:                           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= qnorm_pkg::MIN_LENGTH_SQUARED_RESET;
        end
        else
        begin
            min_len_reg <= min_len_next;
        end
    end

endmodule

// File: rtl/core/qnorm_front.sv
// ----------------------------------------------------------------------------
// qnorm_front
// Front stages: input register with magnitude and sign, squares, then the
// sum of squares and its comparison with the minimum.
// ----------------------------------------------------------------------------
module qnorm_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic [qnorm_pkg::CFG_W-1:0]              min_length_squared,
    qnorm_in_if.sink                                 item,
    output logic                                     valid,
    output qnorm_pkg::ctl_t                          ctl,
    output qnorm_pkg::sq_t [qnorm_pkg::LANES-1:0]    sq
);

    localparam int LANES = qnorm_pkg::LANES;
    localparam int MAG_W = qnorm_pkg::MAG_W;
    localparam int SUM_W = qnorm_pkg::SUM_W;
    localparam int CFG_W = qnorm_pkg::CFG_W;
    localparam int CMP_W = (SUM_W > CFG_W) ? SUM_W : CFG_W;

    logic [qnorm_pkg::IN_WIDTH-1:0] comp [LANES];

    logic [LANES-1:0][MAG_W-1:0]   a_mag_next;
    logic [LANES-1:0]              a_neg_next;
    logic                          a_valid_reg;
    logic [LANES-1:0][MAG_W-1:0]   a_mag_reg;
    logic [LANES-1:0]              a_neg_reg;

    logic [LANES-1:0][2*MAG_W-1:0] prod;
    qnorm_pkg::sq_t [LANES-1:0]    b_sq_next;
    logic                          b_valid_reg;
    qnorm_pkg::sq_t [LANES-1:0]    b_sq_reg;
    logic [LANES-1:0]              b_neg_reg;

    logic [SUM_W-1:0]              c_sum_next;
    logic                          c_short_next;
    logic                          c_valid_reg;
    qnorm_pkg::ctl_t               c_ctl_reg;
    qnorm_pkg::sq_t [LANES-1:0]    c_sq_reg;

    assign comp[0] = item.in_w;
    assign comp[1] = item.in_x;
    assign comp[2] = item.in_y;
    assign comp[3] = item.in_z;

    assign item.ready = en;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            a_neg_next[i] = comp[i][MAG_W-1];
            a_mag_next[i] = comp[i][MAG_W-1] ? (~comp[i] + 1'b1) : comp[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i]      = {{MAG_W{1'b0}}, a_mag_reg[i]} * {{MAG_W{1'b0}}, a_mag_reg[i]};
            b_sq_next[i] = prod[i][qnorm_pkg::SQ_W-1:0];
        end
    end

    always_comb
    begin
        c_sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            c_sum_next = c_sum_next + SUM_W'(b_sq_reg[i]);
        end
        c_short_next = CMP_W'(c_sum_next) <= CMP_W'(min_length_squared);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= item.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg           <= a_mag_next;
            a_neg_reg           <= a_neg_next;
            b_sq_reg            <= b_sq_next;
            b_neg_reg           <= a_neg_reg;
            c_sq_reg            <= b_sq_reg;
            c_ctl_reg.sum       <= c_sum_next;
            c_ctl_reg.neg       <= b_neg_reg;
            c_ctl_reg.too_short <= c_short_next;
        end
    end

    assign valid = c_valid_reg;
    assign ctl   = c_ctl_reg;
    assign sq    = c_sq_reg;

endmodule

// File: rtl/core/qnorm_root.sv
// ----------------------------------------------------------------------------
// qnorm_root
// Restoring root recurrence, one result bit per stage for all four lanes.
// Finds the largest r with r*r*S <= c*c*2^SHIFT.
// ----------------------------------------------------------------------------
module qnorm_root (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  qnorm_pkg::ctl_t                           in_ctl,
    input  qnorm_pkg::sq_t [qnorm_pkg::LANES-1:0]     in_sq,
    output logic                                      out_valid,
    output qnorm_pkg::ctl_t                           out_ctl,
    output qnorm_pkg::root_t [qnorm_pkg::LANES-1:0]   out_root
);

    localparam int LANES = qnorm_pkg::LANES;
    localparam int NS    = qnorm_pkg::R_W;
    localparam int R_W   = qnorm_pkg::R_W;
    localparam int D_W   = qnorm_pkg::D_W;
    localparam int P_W   = qnorm_pkg::P_W;
    localparam int T_W   = qnorm_pkg::T_W;

    logic                              valid_reg [NS];
    qnorm_pkg::ctl_t                   ctl_reg   [NS];
    logic [LANES-1:0][R_W-1:0]         root_reg  [NS];
    logic [LANES-1:0][D_W-1:0]         rem_reg   [NS-1];
    logic [LANES-1:0][P_W-1:0]         acc_reg   [NS-1];

    logic                              valid_in [NS];
    qnorm_pkg::ctl_t                   ctl_in   [NS];
    logic [LANES-1:0][R_W-1:0]         root_in  [NS];
    logic [LANES-1:0][D_W-1:0]         rem_in   [NS];
    logic [LANES-1:0][P_W-1:0]         acc_in   [NS];

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        localparam int K = NS - 1 - g;

        logic [LANES-1:0]          take;
        logic [LANES-1:0][T_W-1:0] trial;
        logic [LANES-1:0][R_W-1:0] root_next;

        if (g == 0)
        begin : g_head
            assign valid_in[g] = in_valid;
            assign ctl_in[g]   = in_ctl;
            assign root_in[g]  = '0;
            assign acc_in[g]   = '0;
            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_in[g][i] = D_W'(in_sq[i]) << qnorm_pkg::SHIFT;
                end
            end
        end
        else
        begin : g_link
            assign valid_in[g] = valid_reg[g-1];
            assign ctl_in[g]   = ctl_reg[g-1];
            assign root_in[g]  = root_reg[g-1];
            assign rem_in[g]   = rem_reg[g-1];
            assign acc_in[g]   = acc_reg[g-1];
        end

        // trial subtrahend (2^(K+1)*r + 2^(2K)) * S, with r*S held in acc
        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                trial[i] = (T_W'(acc_in[g][i]) << (K + 1))
                         + (T_W'(ctl_in[g].sum) << (2 * K));
                take[i]  = trial[i] <= T_W'(rem_in[g][i]);
                root_next[i] = take[i] ? (root_in[g][i] | (R_W'(1) << K)) : root_in[g][i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[g]  <= ctl_in[g];
                root_reg[g] <= root_next;
            end
        end

        if (g < NS - 1)
        begin : g_carry
            logic [LANES-1:0][D_W-1:0] rem_next;
            logic [LANES-1:0][P_W-1:0] acc_next;

            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_next[i] = take[i] ? (rem_in[g][i] - trial[i][D_W-1:0])
                                          : rem_in[g][i];
                    acc_next[i] = take[i] ? (acc_in[g][i] + (P_W'(ctl_in[g].sum) << K))
                                          : acc_in[g][i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next;
                    acc_reg[g] <= acc_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_ctl   = ctl_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule

// File: rtl/core/qnorm_outbuf.sv
// ----------------------------------------------------------------------------
// qnorm_outbuf
// Rounding and sign, output register and one-beat skid stage.
// ----------------------------------------------------------------------------
module qnorm_outbuf (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  qnorm_pkg::ctl_t                           in_ctl,
    input  qnorm_pkg::root_t [qnorm_pkg::LANES-1:0]   in_root,
    output logic                                      en,
    qnorm_out_if.source                               result
);

    localparam int LANES = qnorm_pkg::LANES;
    localparam int OUT_W = qnorm_pkg::OUT_WIDTH;
    localparam int R_W   = qnorm_pkg::R_W;
    localparam int UP_W  = R_W + 1;

    typedef struct packed {
        logic [LANES-1:0][OUT_W-1:0] comp;
        logic                        too_short;
    } beat_t;

    // nearest odd root below r gives the rounded magnitude (r + 1) / 2
    function automatic logic [OUT_W-1:0] finish(
        input qnorm_pkg::root_t root,
        input logic             neg,
        input logic             zero
    );
        logic [UP_W-1:0]  up;
        logic [OUT_W-1:0] mag;
        up  = {1'b0, root} + UP_W'(1);
        mag = OUT_W'(up[UP_W-1:1]);
        if (zero)
        begin
            return '0;
        end
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    beat_t res_next;
    logic  take;
    logic  out_valid_reg;
    logic  out_valid_next;
    beat_t out_data_reg;
    beat_t out_data_next;
    logic  skid_valid_reg;
    logic  skid_valid_next;
    beat_t skid_data_reg;
    beat_t skid_data_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            res_next.comp[i] = finish(in_root[i], in_ctl.neg[i], in_ctl.too_short);
        end
        res_next.too_short = in_ctl.too_short;
    end

    assign en   = !skid_valid_reg;
    assign take = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = res_next;
            end
        end
        else if (in_valid && en)
        begin
            // park the beat leaving the pipeline while the output is stalled
            skid_valid_next = 1'b1;
            skid_data_next  = res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.out_w     = signed'(out_data_reg.comp[0]);
    assign result.out_x     = signed'(out_data_reg.comp[1]);
    assign result.out_y     = signed'(out_data_reg.comp[2]);
    assign result.out_z     = signed'(out_data_reg.comp[3]);
    assign result.too_short = out_data_reg.too_short;

endmodule

// File: rtl/core/quaternion_normalizer_top.sv
// ----------------------------------------------------------------------------
// quaternion_normalizer_top
// Scales a Q2.13 quaternion to unit length, giving Q1.14 components rounded
// to nearest (ties away from zero). One beat is accepted every cycle while
// the skid stage is empty. The result passes through an input register
// loaded at the accepting edge, a squaring stage, a sum-and-compare stage,
// sixteen stages of the restoring root recurrence (one result bit per stage
// for all four components at once) and the output register. When the sum
// of squares is at or below min_length_squared (APB offset 0x0, Q6.26,
// reset 1) the components are zero and too_short is set. A one-beat skid
// stage parks the beat leaving the pipeline while the output stalls; the
// pipeline and the input then hold until the skid drains.
// ----------------------------------------------------------------------------
module quaternion_normalizer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qnorm_pkg::APB_AW-1:0]   paddr,
    input  logic [qnorm_pkg::APB_DW-1:0]   pwdata,
    output logic [qnorm_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    qnorm_in_if.sink                       item,
    qnorm_out_if.source                    result
);

    logic [qnorm_pkg::CFG_W-1:0]                   min_length_squared;
    logic                                          en;
    logic                                          front_valid;
    qnorm_pkg::ctl_t                               front_ctl;
    qnorm_pkg::sq_t   [qnorm_pkg::LANES-1:0]       front_sq;
    logic                                          root_valid;
    qnorm_pkg::ctl_t                               root_ctl;
    qnorm_pkg::root_t [qnorm_pkg::LANES-1:0]       root_val;

    qnorm_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .min_length_squared (min_length_squared)
    );

    qnorm_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .min_length_squared (min_length_squared),
        .item               (item),
        .valid              (front_valid),
        .ctl                (front_ctl),
        .sq                 (front_sq)
    );

    qnorm_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_ctl    (front_ctl),
        .in_sq     (front_sq),
        .out_valid (root_valid),
        .out_ctl   (root_ctl),
        .out_root  (root_val)
    );

    qnorm_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .in_ctl   (root_ctl),
        .in_root  (root_val),
        .en       (en),
        .result   (result)
    );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion normaliser. Each accepted quaternion
// is run through an independent integer predictor (exact sum of squares,
// threshold test, integer square root of the scaled ratio, round to nearest)
// and the expected unit quaternion is queued. Every result beat is checked
// field by field against the oldest entry. The threshold register is written
// and read back over APB between phases. In the phases that enable them, the
// input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IN_WIDTH  = qnorm_pkg::IN_WIDTH;
    localparam int OUT_WIDTH = qnorm_pkg::OUT_WIDTH;
    localparam int LANES     = qnorm_pkg::LANES;
    localparam int CFG_W     = qnorm_pkg::CFG_W;
    localparam int APB_AW    = qnorm_pkg::APB_AW;
    localparam int APB_DW    = qnorm_pkg::APB_DW;
    localparam int REG_IDX_W = qnorm_pkg::REG_IDX_W;
    localparam int OFRAC     = qnorm_pkg::OFRAC;
    localparam int SHIFT     = qnorm_pkg::SHIFT;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int HOLD_OFF_CYCLES  = 100;
    localparam int END_DRAIN        = 40;
    localparam int WATCHDOG_LIMIT   = 2000;

    localparam int COMP_MIN = -(1 << (IN_WIDTH - 1));
    localparam int COMP_MAX = (1 << (IN_WIDTH - 1)) - 1;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED   = qnorm_pkg::REG_MIN_LENGTH_SQUARED + 1'b1;
    localparam logic [APB_AW-1:0]    ADDR_MIN_LEN = {qnorm_pkg::REG_MIN_LENGTH_SQUARED, 2'b00};
    localparam logic [APB_AW-1:0]    ADDR_UNUSED  = {REG_UNUSED, 2'b00};

    typedef logic signed [IN_WIDTH-1:0]  in_comp_t;
    typedef logic signed [OUT_WIDTH-1:0] out_comp_t;
    typedef in_comp_t in_quat_t [LANES];

    typedef struct {
        out_comp_t comp [LANES];
        logic      too_short;
    } unit_quat_t;

    class unit_quat_scoreboard;

        unit_quat_t       expected_unit_quats [$];
        logic [CFG_W-1:0] min_len;
        int               mismatch_count;

        function new();
            min_len        = qnorm_pkg::MIN_LENGTH_SQUARED_RESET;
            mismatch_count = 0;
        endfunction

        function unit_quat_t predict_unit_quat(in_quat_t quat);
            unit_quat_t res;
            longint     mag [LANES];
            longint     sum_sq;
            longint     ratio;
            longint     root;
            longint     trial;
            sum_sq = 0;
            for (int i = 0; i < LANES; i++)
            begin
                mag[i] = quat[i][IN_WIDTH-1] ? -longint'(quat[i]) : longint'(quat[i]);
                sum_sq += mag[i] * mag[i];
            end
            res.too_short = (sum_sq <= longint'(min_len));
            for (int i = 0; i < LANES; i++)
            begin
                res.comp[i] = '0;
                if (!res.too_short)
                begin
                    // round(m * 2^OFRAC / sqrt(S)) = (isqrt(m^2 * 2^SHIFT / S) + 1) / 2
                    ratio = ((mag[i] * mag[i]) << SHIFT) / sum_sq;
                    root  = 0;
                    for (int b = OFRAC + 1; b >= 0; b--)
                    begin
                        trial = root | (longint'(1) << b);
                        if (trial * trial <= ratio)
                            root = trial;
                    end
                    root = (root + 1) >> 1;
                    res.comp[i] = quat[i][IN_WIDTH-1] ? out_comp_t'(-root) : out_comp_t'(root);
                end
            end
            return res;
        endfunction

        task report_mismatch(string what);
            $display("ERROR %0t: %s", $time, what);
            mismatch_count++;
        endtask

        function void note_quat(in_quat_t quat);
            expected_unit_quats.push_back(predict_unit_quat(quat));
        endfunction

        task check_unit_quat(unit_quat_t got);
            unit_quat_t exp_q;
            if (expected_unit_quats.size() == 0)
            begin
                report_mismatch("result beat with nothing outstanding");
                return;
            end
            exp_q = expected_unit_quats.pop_front();
            for (int i = 0; i < LANES; i++)
                if (got.comp[i] !== exp_q.comp[i])
                    report_mismatch($sformatf("lane %0d (w,x,y,z): got %0d, expected %0d",
                                              i, got.comp[i], exp_q.comp[i]));
            if (got.too_short !== exp_q.too_short)
                report_mismatch($sformatf("too_short: got %b, expected %b",
                                          got.too_short, exp_q.too_short));
        endtask

    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    qnorm_in_if  item_if ();
    qnorm_out_if result_if ();

    unit_quat_scoreboard unit_sb;
    bit                  sender_idle_on;
    bit                  sink_idle_on;
    int                  hold_off_asked;
    int                  stalled_cycles;

    quaternion_normalizer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_if.sink),
        .result  (result_if.source)
    );

    initial
        clk = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic int extreme_comp();
        case ($urandom_range(0, 7))
            0: return COMP_MIN;
            1: return COMP_MIN + 1;
            2: return COMP_MIN / 2;
            3: return -1;
            4: return 0;
            5: return 1;
            6: return -(COMP_MIN / 2);
            default: return COMP_MAX;
        endcase
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MIN_LEN)
            unit_sb.min_len = data;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_min_len_readback();
        logic [APB_DW-1:0] rd;
        apb_read(ADDR_MIN_LEN, rd);
        if (rd !== unit_sb.min_len)
            unit_sb.report_mismatch($sformatf("min_length_squared read %h, expected %h",
                                              rd, unit_sb.min_len));
    endtask

    task automatic send_quat(input int w, input int x, input int y, input int z);
        int gap;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 99) >= 60)
            gap = idle_len();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.in_w  <= in_comp_t'(w);
        item_if.in_x  <= in_comp_t'(x);
        item_if.in_y  <= in_comp_t'(y);
        item_if.in_z  <= in_comp_t'(z);
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random_quat();
        int c [LANES];
        int kind;
        int lane;
        int root;
        kind = int'($urandom_range(0, 99));
        lane = int'($urandom_range(0, LANES - 1));
        for (int i = 0; i < LANES; i++)
            c[i] = 0;
        if (kind < 40)
        begin
            for (int i = 0; i < LANES; i++)
                c[i] = int'(in_comp_t'($urandom));
        end
        else if (kind < 55)
        begin
            for (int i = 0; i < LANES; i++)
                c[i] = extreme_comp();
        end
        else if (kind < 70)
            c[lane] = int'(in_comp_t'($urandom));
        else if (kind < 85)
        begin
            // land the sum of squares close to the threshold
            root = int'($sqrt(real'(unit_sb.min_len)));
            if (root > COMP_MAX - 2)
                root = COMP_MAX - 2;
            c[lane] = root + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 1)
                c[lane] = -c[lane];
            c[(lane + 1) % LANES] = int'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            for (int i = 0; i < LANES; i++)
                c[i] = int'($urandom_range(0, 510)) - 255;
        end
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task automatic wait_drained();
        while (unit_sb.expected_unit_quats.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        unit_quat_t got;
        in_quat_t   quat;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got.comp[0]   = result_if.out_w;
                got.comp[1]   = result_if.out_x;
                got.comp[2]   = result_if.out_y;
                got.comp[3]   = result_if.out_z;
                got.too_short = result_if.too_short;
                unit_sb.check_unit_quat(got);
            end
            if (item_if.valid && item_if.ready)
            begin
                quat[0] = item_if.in_w;
                quat[1] = item_if.in_x;
                quat[2] = item_if.in_y;
                quat[3] = item_if.in_z;
                unit_sb.note_quat(quat);
            end
            if ((result_if.valid && result_if.ready) || (item_if.valid && item_if.ready) || psel)
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int served;
        stall_left = 0;
        served     = 0;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (served != hold_off_asked)
            begin
                served++;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 99) < 25)
            begin
                result_if.ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] min_settings [PHASES];
        unit_sb        = new();
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        hold_off_asked = 0;
        stalled_cycles = 0;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        item_if.valid <= 1'b0;
        item_if.in_w  <= '0;
        item_if.in_x  <= '0;
        item_if.in_y  <= '0;
        item_if.in_z  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_min_len_readback();

        // reset threshold: zero and unit-sum quaternions are refused
        send_quat(0, 0, 0, 0);
        send_quat(1, 0, 0, 0);
        send_quat(0, 0, 0, -1);
        send_quat(1, 1, 0, 0);
        send_quat(COMP_MAX, 0, 0, 0);
        send_quat(COMP_MIN, 0, 0, 0);
        send_quat(0, -2, 0, 0);
        send_quat(0, 0, COMP_MAX, 0);
        send_quat(0, 0, 0, COMP_MIN);
        send_quat(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        send_quat(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_quat(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);
        send_quat(8192, 0, 0, 0);
        send_quat(4096, 4096, 4096, -4096);
        send_quat(3, 4, 0, 0);
        send_quat(-3, 0, -4, 0);
        send_quat(0, 5, 0, -12);
        send_quat(1, -1, 1, -1);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 2, 3, 4);
        send_quat(int'(in_comp_t'(16'h5555)), int'(in_comp_t'(16'hAAAA)),
                  int'(in_comp_t'(16'hAAAA)), int'(in_comp_t'(16'h5555)));
        item_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        // a write beyond the last register must leave the threshold alone
        apb_write(ADDR_UNUSED, $urandom);
        check_min_len_readback();

        min_settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0400_0000, $urandom,
                         $urandom_range(0, 32'h0010_0000), 32'h0000_0001, $urandom,
                         $urandom_range(0, 32'h1000_0000)};

        for (int phase = 0; phase < PHASES; phase++)
        begin
            sender_idle_on = (phase % 3 != 2);
            sink_idle_on   = (phase % 4 != 1);
            apb_write(ADDR_MIN_LEN, min_settings[phase]);
            check_min_len_readback();
            if (min_settings[phase] == '0)
                send_quat(0, 0, 0, 0);
            if (min_settings[phase] == '1)
            begin
                send_quat(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
                send_quat(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
            end
            if (phase == 2)
                hold_off_asked++;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 4 && n == RANDOM_PER_PHASE / 2)
                begin
                    item_if.valid <= 1'b0;
                    @(posedge clk);
                    wait_drained();
                end
                send_random_quat();
            end
            item_if.valid <= 1'b0;
            @(posedge clk);
            wait_drained();
        end

        repeat (END_DRAIN) @(posedge clk);
        if (unit_sb.mismatch_count == 0 && unit_sb.expected_unit_quats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: quaternion_normalizer_top.f
rtl/core/qnorm_pkg.sv
rtl/core/qnorm_in_if.sv
rtl/core/qnorm_out_if.sv
rtl/core/qnorm_cfg.sv
rtl/core/qnorm_front.sv
rtl/core/qnorm_root.sv
rtl/core/qnorm_outbuf.sv
rtl/core/quaternion_normalizer_top.sv
verif/tb_top.sv
